### hdl/b64dec_pkg.sv
package b64dec_pkg;

  localparam int COUNT_BITS = 24;

  localparam logic REQ_CHAR   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_AFTER_PAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_EXCESS_PAD = 3'd4;
  localparam logic [2:0] ST_LEFTOVER   = 3'd5;

  typedef struct packed {
    logic       req_type;
    logic [7:0] text_char;
  } req_item_t;

  typedef struct packed {
    logic                  out_kind;
    logic [7:0]            data_byte;
    logic [2:0]            status;
    logic [COUNT_BITS-1:0] byte_count;
  } rsp_item_t;

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_PAD,
    CLS_SYM,
    CLS_BAD
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [5:0]  value;
  } sym_info_t;

endpackage

### hdl/b64dec_classify.sv
module b64dec_classify import b64dec_pkg::*; (
  input  logic [7:0] text_char,
  output sym_info_t  info
);

  always_comb begin
    info.cls   = CLS_BAD;
    info.value = 6'd0;
    if (text_char == 8'h20 || text_char == 8'h09 || text_char == 8'h0D ||
        text_char == 8'h0A) begin
      info.cls = CLS_SPACE;
    end else if (text_char == 8'h3D) begin
      info.cls = CLS_PAD;
    end else if (text_char >= 8'h41 && text_char <= 8'h5A) begin
      info.cls   = CLS_SYM;
      info.value = 6'(text_char - 8'h41);
    end else if (text_char >= 8'h61 && text_char <= 8'h7A) begin
      info.cls   = CLS_SYM;
      info.value = 6'(text_char - 8'h61 + 8'd26);
    end else if (text_char >= 8'h30 && text_char <= 8'h39) begin
      info.cls   = CLS_SYM;
      info.value = 6'(text_char - 8'h30 + 8'd52);
    end else if (text_char == 8'h2B) begin
      info.cls   = CLS_SYM;
      info.value = 6'h3E;
    end else if (text_char == 8'h2F) begin
      info.cls   = CLS_SYM;
      info.value = 6'h3F;
    end
  end

endmodule

### hdl/b64dec_core.sv
module b64dec_core import b64dec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  req_item_t             item,
  input  logic [COUNT_BITS-1:0] capacity,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_item_t             rsp
);

  logic [5:0]            residual_bits, residual_bits_next;
  logic [2:0]            residual_count, residual_count_next;
  logic [1:0]            pad_count, pad_count_next;
  logic [2:0]            error_code, error_code_next;
  logic [COUNT_BITS-1:0] emitted_count, emitted_count_next;

  sym_info_t  info;
  logic       fire;
  logic       produce;
  rsp_item_t  result;
  logic [11:0] joined;
  logic [11:0] shifted;
  logic [2:0]  keep;

  b64dec_classify u_classify (
    .text_char (item.text_char),
    .info      (info)
  );

  assign item_ready = !rsp_valid || rsp_ready;
  assign fire       = item_valid && item_ready;

  // keep is the number of bits left over once a byte goes out
  assign joined  = {residual_bits, info.value};
  assign keep    = residual_count - 3'd2;
  assign shifted = joined >> keep;

  always_comb begin
    residual_bits_next  = residual_bits;
    residual_count_next = residual_count;
    pad_count_next      = pad_count;
    error_code_next     = error_code;
    emitted_count_next  = emitted_count;
    produce             = 1'b0;
    result.out_kind     = KIND_DATA;
    result.data_byte    = 8'd0;
    result.status       = ST_OK;
    result.byte_count   = '0;

    if (item.req_type == REQ_FINISH) begin
      produce           = 1'b1;
      result.out_kind   = KIND_STATUS;
      result.byte_count = emitted_count;
      if (error_code != ST_OK) begin
        result.status = error_code;
      end else if (pad_count == 2'd3) begin
        result.status = ST_EXCESS_PAD;
      end else if (residual_count != 3'd0 && residual_bits != 6'd0) begin
        result.status = ST_LEFTOVER;
      end
      residual_bits_next  = 6'd0;
      residual_count_next = 3'd0;
      pad_count_next      = 2'd0;
      error_code_next     = ST_OK;
      emitted_count_next  = '0;
    end else if (error_code == ST_OK) begin
      case (info.cls)
        CLS_SPACE: begin
        end
        CLS_PAD: begin
          if (pad_count != 2'd3) begin
            pad_count_next = pad_count + 2'd1;
          end
        end
        default: begin
          if (pad_count != 2'd0) begin
            error_code_next = ST_AFTER_PAD;
          end else if (info.cls == CLS_BAD) begin
            error_code_next = ST_BAD_CHAR;
          end else if (residual_count < 3'd2) begin
            residual_bits_next  = info.value;
            residual_count_next = residual_count + 3'd6;
          end else if (emitted_count >= capacity || emitted_count == '1) begin
            error_code_next = ST_OVERFLOW;
          end else begin
            produce             = 1'b1;
            result.data_byte    = shifted[7:0];
            residual_bits_next  = 6'(joined & ((12'd1 << keep) - 12'd1));
            residual_count_next = keep;
            emitted_count_next  = emitted_count + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residual_bits  <= 6'd0;
      residual_count <= 3'd0;
      pad_count      <= 2'd0;
      error_code     <= ST_OK;
      emitted_count  <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (fire) begin
        residual_bits  <= residual_bits_next;
        residual_count <= residual_count_next;
        pad_count      <= pad_count_next;
        error_code     <= error_code_next;
        emitted_count  <= emitted_count_next;
      end
      if (fire && produce) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      rsp <= result;
    end
  end

  a_count_even: assert property (@(posedge clk) disable iff (rst)
    residual_count[0] == 1'b0)
    else $error("residual count is odd");

  a_bits_masked: assert property (@(posedge clk) disable iff (rst)
    (residual_bits >> residual_count) == 6'd0)
    else $error("residual bits above count");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type == REQ_FINISH |=>
      residual_count == 3'd0 && pad_count == 2'd0 && error_code == ST_OK &&
      emitted_count == '0)
    else $error("finish left state behind");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_OK && !(fire && item.req_type == REQ_FINISH) |=>
      error_code == $past(error_code))
    else $error("error code changed without finish");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("pending result dropped");

endmodule

### hdl/base64_stream_decoder.sv
// Base64 text decoder, one character per item. Characters enter a holding
// register and are decoded from there straight into the result register
// once that register is free, and a new item is taken every cycle as long as
// the result side keeps up; the only thing that slows intake is a result left
// waiting in the result register. Whitespace and pad characters give no
// result, an alphabet character gives a data byte whenever eight bits are
// collected, and a finish item gives the status and byte count and starts a
// new stream. The first error sticks until finish. The user must write
// out_capacity (cfg_data) only while the block is idle; the block itself does
// not enforce this. out_capacity resets to the full 24-bit range.
module base64_stream_decoder import b64dec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_item_t             req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_item_t             rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_BITS-1:0] cfg_data
);

  logic [COUNT_BITS-1:0] out_capacity;
  logic                  hold_valid;
  req_item_t             hold;
  logic                  item_ready;

  assign cfg_ready = 1'b1;
  assign req_ready = !hold_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= '1;
      hold_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_capacity <= cfg_data;
      end
      if (req_valid && req_ready) begin
        hold_valid <= 1'b1;
      end else if (item_ready) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  b64dec_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (hold_valid),
    .item_ready (item_ready),
    .item       (hold),
    .capacity   (out_capacity),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule
